FILE: src/wmoth_pkg.sv
package wmoth_pkg;

  // item and result widths
  localparam int DATA_W    = 64;
  localparam int HASH_W    = 32;
  localparam int CNT_W     = 4;

  // serial datapath: one byte-wide digit per cycle
  localparam int DIGIT_W   = 8;
  localparam int NUM_DIG   = DATA_W / DIGIT_W;
  localparam int HALF_DIG  = HASH_W / DIGIT_W;
  localparam int DIG_IDX_W = $clog2(NUM_DIG);

  localparam logic [CNT_W-1:0]  MAX_TAIL   = 4'd8;
  localparam logic [DATA_W-1:0] SEED_VALUE = 64'd123456789;

  // one pass of the serial unit over the accumulator
  typedef enum logic [3:0] {
    OP_ADD_EXT,
    OP_ADD_SHL32,
    OP_ADD_SHR32,
    OP_ADD_SHL10,
    OP_XOR_SHR6,
    OP_XOR_SHL48,
    OP_ADD_SHL3,
    OP_XOR_SHR11,
    OP_ADD_SHL15
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    half;      // 32-bit pass: upper digits cleared, right shifts stop at bit 31
    logic    seed_xor;  // fold the seed constant into the result
  } alu_cmd_t;

  typedef struct packed {
    logic               start;
    logic               load_seed;
    alu_cmd_t           cmd;
    logic [DIGIT_W-1:0] ext_dig;
  } alu_ctl_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIG_IDX_W-1:0] dig_idx;
    logic [HASH_W-1:0]    acc_low;
  } alu_stat_t;

endpackage

FILE: src/wmoth_alu.sv
module wmoth_alu (
  input  logic                clk,
  input  logic                rst,
  input  wmoth_pkg::alu_ctl_t  ctl,
  output wmoth_pkg::alu_stat_t stat
);

  // accumulator rotates right one digit per cycle, so digit j sits at the bottom
  logic [wmoth_pkg::DATA_W-1:0]                    acc;
  logic [wmoth_pkg::DATA_W-wmoth_pkg::DIGIT_W-1:0] part;
  logic                                            carry;
  logic                                            busy;
  logic [wmoth_pkg::DIG_IDX_W-1:0]                 dig_idx;
  wmoth_pkg::alu_cmd_t                             cmd;

  logic [wmoth_pkg::DIGIT_W-1:0] a_dig;
  logic [wmoth_pkg::DIGIT_W-1:0] b_dig;
  logic [wmoth_pkg::DIGIT_W-1:0] res_dig;
  logic [wmoth_pkg::DIGIT_W:0]   sum;
  logic                          use_add;
  logic                          last_dig;
  int                            lim;

  // digit j of (a << k), read from fixed taps of the rotated accumulator
  function automatic logic [wmoth_pkg::DIGIT_W-1:0] shl_dig(
    input logic [wmoth_pkg::DATA_W-1:0]    a_rot,
    input logic [wmoth_pkg::DIG_IDX_W-1:0] j,
    input int                              k
  );
    logic [wmoth_pkg::DIGIT_W-1:0] d;
    int                            pos;
    for (int t = 0; t < wmoth_pkg::DIGIT_W; t++) begin
      pos  = int'(j) * wmoth_pkg::DIGIT_W + t;
      d[t] = (pos >= k) ?
             a_rot[(t - k + wmoth_pkg::DATA_W) % wmoth_pkg::DATA_W] : 1'b0;
    end
    return d;
  endfunction

  // digit j of (a >> k) for a value of lim bits
  function automatic logic [wmoth_pkg::DIGIT_W-1:0] shr_dig(
    input logic [wmoth_pkg::DATA_W-1:0]    a_rot,
    input logic [wmoth_pkg::DIG_IDX_W-1:0] j,
    input int                              k,
    input int                              w
  );
    logic [wmoth_pkg::DIGIT_W-1:0] d;
    int                            pos;
    for (int t = 0; t < wmoth_pkg::DIGIT_W; t++) begin
      pos  = int'(j) * wmoth_pkg::DIGIT_W + t + k;
      d[t] = (pos < w) ? a_rot[(t + k) % wmoth_pkg::DATA_W] : 1'b0;
    end
    return d;
  endfunction

  // operand digit and combine kind
  always_comb begin
    a_dig    = acc[wmoth_pkg::DIGIT_W-1:0];
    lim      = cmd.half ? wmoth_pkg::HASH_W : wmoth_pkg::DATA_W;
    last_dig = (dig_idx == wmoth_pkg::DIG_IDX_W'(wmoth_pkg::NUM_DIG - 1));
    unique case (cmd.op)
      wmoth_pkg::OP_ADD_EXT:   begin b_dig = ctl.ext_dig;                   use_add = 1'b1; end
      wmoth_pkg::OP_ADD_SHL32: begin b_dig = shl_dig(acc, dig_idx, 32);     use_add = 1'b1; end
      wmoth_pkg::OP_ADD_SHR32: begin b_dig = shr_dig(acc, dig_idx, 32, lim); use_add = 1'b1; end
      wmoth_pkg::OP_ADD_SHL10: begin b_dig = shl_dig(acc, dig_idx, 10);     use_add = 1'b1; end
      wmoth_pkg::OP_XOR_SHR6:  begin b_dig = shr_dig(acc, dig_idx, 6, lim); use_add = 1'b0; end
      wmoth_pkg::OP_XOR_SHL48: begin b_dig = shl_dig(acc, dig_idx, 48);     use_add = 1'b0; end
      wmoth_pkg::OP_ADD_SHL3:  begin b_dig = shl_dig(acc, dig_idx, 3);      use_add = 1'b1; end
      wmoth_pkg::OP_XOR_SHR11: begin b_dig = shr_dig(acc, dig_idx, 11, lim); use_add = 1'b0; end
      wmoth_pkg::OP_ADD_SHL15: begin b_dig = shl_dig(acc, dig_idx, 15);     use_add = 1'b1; end
      default:                 begin b_dig = '0;                            use_add = 1'b0; end
    endcase
  end

  // digit adder or xor, seed fold, upper half cleared on 32-bit passes
  always_comb begin
    sum     = {1'b0, a_dig} + {1'b0, b_dig} + {{wmoth_pkg::DIGIT_W{1'b0}}, carry};
    res_dig = use_add ? sum[wmoth_pkg::DIGIT_W-1:0] : (a_dig ^ b_dig);
    if (cmd.seed_xor) begin
      res_dig = res_dig ^ wmoth_pkg::SEED_VALUE[dig_idx*wmoth_pkg::DIGIT_W +: wmoth_pkg::DIGIT_W];
    end
    if (cmd.half && (dig_idx >= wmoth_pkg::DIG_IDX_W'(wmoth_pkg::HALF_DIG))) begin
      res_dig = '0;
    end
  end

  // digit sequencing and accumulator update
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      dig_idx <= '0;
      carry   <= 1'b0;
      acc     <= wmoth_pkg::SEED_VALUE;
    end else if (busy) begin
      part    <= {res_dig, part[wmoth_pkg::DATA_W-wmoth_pkg::DIGIT_W-1:wmoth_pkg::DIGIT_W]};
      carry   <= sum[wmoth_pkg::DIGIT_W];
      dig_idx <= dig_idx + 1'b1;
      if (last_dig) begin
        acc  <= {res_dig, part};
        busy <= 1'b0;
      end else begin
        acc <= {acc[wmoth_pkg::DIGIT_W-1:0], acc[wmoth_pkg::DATA_W-1:wmoth_pkg::DIGIT_W]};
      end
    end else if (ctl.start) begin
      busy    <= 1'b1;
      cmd     <= ctl.cmd;
      dig_idx <= '0;
      carry   <= 1'b0;
    end else if (ctl.load_seed) begin
      acc <= wmoth_pkg::SEED_VALUE;
    end
  end

  assign stat.busy    = busy;
  assign stat.done    = busy && last_dig;
  assign stat.dig_idx = dig_idx;
  assign stat.acc_low = acc[wmoth_pkg::HASH_W-1:0];

  // a pass always begins at the lowest digit with no carry
  a_start_digit: assert property (@(posedge clk) disable iff (rst)
    (ctl.start && !busy) |=> (busy && dig_idx == '0 && !carry))
    else $error("serial pass did not start at digit zero");

  // a finished pass leaves the unit free for the next command
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> !busy)
    else $error("unit still busy after last digit");

endmodule

FILE: src/wmoth_ctrl.sv
module wmoth_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wmoth_pkg::DATA_W-1:0]        in_word,
  input  logic [wmoth_pkg::CNT_W-1:0]         in_count,
  input  logic                                in_last,
  output wmoth_pkg::alu_ctl_t                  alu_ctl,
  input  wmoth_pkg::alu_stat_t                 alu_stat,
  input  logic                                out_free,
  output logic                                emit
);

  localparam int OPI_W = 3;
  localparam logic [OPI_W-1:0] PREMIX_LAST = 3'd5;
  localparam logic [OPI_W-1:0] ROUND_LAST  = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREMIX,
    ST_TAIL,
    ST_FINAL,
    ST_EMIT
  } state_t;

  state_t                         state;
  logic [OPI_W-1:0]               opi;
  logic [wmoth_pkg::DATA_W-1:0]   word;
  logic [wmoth_pkg::CNT_W-1:0]    tail_cnt;
  logic [wmoth_pkg::CNT_W-1:0]    tail_step;
  logic [wmoth_pkg::CNT_W-1:0]    cnt_sat;
  logic                           accept;
  logic                           op_phase;
  wmoth_pkg::alu_cmd_t            cmd_sel;

  // command lists for the word mix, each tail byte and the finish
  function automatic wmoth_pkg::alu_cmd_t mk_cmd(input wmoth_pkg::alu_op_t op,
                                                 input logic half, input logic sx);
    wmoth_pkg::alu_cmd_t c;
    c.op       = op;
    c.half     = half;
    c.seed_xor = sx;
    return c;
  endfunction

  always_comb begin
    cmd_sel = mk_cmd(wmoth_pkg::OP_ADD_EXT, 1'b0, 1'b0);
    unique case (state)
      ST_PREMIX: begin
        unique case (opi)
          3'd0:    cmd_sel = mk_cmd(wmoth_pkg::OP_ADD_EXT,   1'b0, 1'b0);
          3'd1:    cmd_sel = mk_cmd(wmoth_pkg::OP_ADD_SHL32, 1'b0, 1'b0);
          3'd2:    cmd_sel = mk_cmd(wmoth_pkg::OP_ADD_SHR32, 1'b0, 1'b0);
          3'd3:    cmd_sel = mk_cmd(wmoth_pkg::OP_ADD_SHL10, 1'b0, 1'b0);
          3'd4:    cmd_sel = mk_cmd(wmoth_pkg::OP_XOR_SHR6,  1'b0, 1'b0);
          default: cmd_sel = mk_cmd(wmoth_pkg::OP_XOR_SHL48, 1'b0, 1'b1);
        endcase
      end
      ST_TAIL: begin
        unique case (opi)
          3'd0:    cmd_sel = mk_cmd(wmoth_pkg::OP_ADD_EXT,   1'b1, 1'b0);
          3'd1:    cmd_sel = mk_cmd(wmoth_pkg::OP_ADD_SHL10, 1'b1, 1'b0);
          default: cmd_sel = mk_cmd(wmoth_pkg::OP_XOR_SHR6,  1'b1, 1'b0);
        endcase
      end
      ST_FINAL: begin
        unique case (opi)
          3'd0:    cmd_sel = mk_cmd(wmoth_pkg::OP_ADD_SHL3,  1'b1, 1'b0);
          3'd1:    cmd_sel = mk_cmd(wmoth_pkg::OP_XOR_SHR11, 1'b1, 1'b0);
          default: cmd_sel = mk_cmd(wmoth_pkg::OP_ADD_SHL15, 1'b1, 1'b0);
        endcase
      end
      default: cmd_sel = mk_cmd(wmoth_pkg::OP_ADD_EXT, 1'b0, 1'b0);
    endcase
  end

  // handshake and unit control
  always_comb begin
    in_ready  = (state == ST_IDLE);
    accept    = in_valid && in_ready;
    cnt_sat   = (in_count > wmoth_pkg::MAX_TAIL) ? wmoth_pkg::MAX_TAIL : in_count;
    op_phase  = (state == ST_PREMIX) || (state == ST_TAIL) || (state == ST_FINAL);
    emit      = (state == ST_EMIT) && out_free;

    alu_ctl.start     = op_phase && !alu_stat.busy;
    alu_ctl.load_seed = emit;
    alu_ctl.cmd       = cmd_sel;
    // tail byte is sign-extended: its top bit fills the higher digits
    if (state == ST_TAIL) begin
      alu_ctl.ext_dig = (alu_stat.dig_idx == '0) ? word[wmoth_pkg::DIGIT_W-1:0]
                                                 : {wmoth_pkg::DIGIT_W{word[wmoth_pkg::DIGIT_W-1]}};
    end else begin
      alu_ctl.ext_dig = word[wmoth_pkg::DIGIT_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      opi       <= '0;
      tail_step <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            word      <= in_word;
            tail_cnt  <= cnt_sat;
            tail_step <= '0;
            opi       <= '0;
            if (!in_last) begin
              state <= ST_PREMIX;
            end else if (cnt_sat == '0) begin
              state <= ST_FINAL;
            end else begin
              state <= ST_TAIL;
            end
          end
        end
        ST_PREMIX: begin
          // the word streams out one digit per cycle during the add pass
          if (alu_stat.busy && opi == '0) begin
            word <= word >> wmoth_pkg::DIGIT_W;
          end
          if (alu_stat.done) begin
            if (opi == PREMIX_LAST) begin
              opi   <= '0;
              state <= ST_IDLE;
            end else begin
              opi <= opi + 1'b1;
            end
          end
        end
        ST_TAIL: begin
          if (alu_stat.done) begin
            if (opi == ROUND_LAST) begin
              opi       <= '0;
              word      <= word >> wmoth_pkg::DIGIT_W;
              tail_step <= tail_step + 1'b1;
              if (tail_step == tail_cnt - 1'b1) begin
                state <= ST_FINAL;
              end
            end else begin
              opi <= opi + 1'b1;
            end
          end
        end
        ST_FINAL: begin
          if (alu_stat.done) begin
            if (opi == ROUND_LAST) begin
              opi   <= '0;
              state <= ST_EMIT;
            end else begin
              opi <= opi + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            tail_step <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // an accepted item closes the input in the cycle after the transfer
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input reopened right after transfer");

  // the serial unit only finishes passes while an operation phase is active
  a_done_in_phase: assert property (@(posedge clk) disable iff (rst)
    alu_stat.done |-> (state == ST_PREMIX || state == ST_TAIL || state == ST_FINAL))
    else $error("pass finished outside an operation phase");

endmodule

FILE: src/word_mix_oat_tail_hash32.sv
// Word-mix one-at-a-time hash. Feed a buffer as 64-bit little-endian words on
// the s_axis side with tlast low; each is folded into a 64-bit running value
// (add, shift/add/xor mix, seed xor). The final 0 to 8 bytes go in one transfer
// with tlast high and the byte count in tuser (counts above 8 act as 8); for a
// buffer of a multiple of 8 bytes that is the last full word with count 8. The
// 32-bit hash then appears on m_axis and the running value returns to the seed.
// All arithmetic runs through one byte-wide serial adder/xor unit that works
// through the eight digits of each 64-bit operation in turn: a word transfer
// runs six operations, a last transfer with n tail bytes three per tail byte
// and three more to finish. A finished hash sits in an output register, so
// new input is taken while it waits to be read.
module word_mix_oat_tail_hash32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // data_word[63:0]
  input  logic [3:0]  s_axis_tuser,   // tail_count[3:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // hash_value[31:0]
);

  wmoth_pkg::alu_ctl_t  alu_ctl;
  wmoth_pkg::alu_stat_t alu_stat;
  logic                 out_free;
  logic                 emit;

  wmoth_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_word  (s_axis_tdata),
    .in_count (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .alu_ctl  (alu_ctl),
    .alu_stat (alu_stat),
    .out_free (out_free),
    .emit     (emit)
  );

  wmoth_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (alu_ctl),
    .stat (alu_stat)
  );

  // output register: free when empty or being read this cycle
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= alu_stat.acc_low;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // a finished hash always lands in the output register
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_axis_tvalid)
    else $error("hash lost on the way to the output register");

endmodule
